### sv/cfve_pkg.sv
// shared types and constants for the chain factor verify and eliminate block
package cfve_pkg;

	localparam int WORD_W  = 62;
	localparam int COUNT_W = 17;
	localparam int POS_W   = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CHAIN_KIND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TERM_TYPE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_K      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_K      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_K     = 3'd6;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_VERIFY = 1'b1;

	localparam logic [1:0] TERM_BASE_POWER = 2'd0;

	typedef struct packed {
		logic              command;
		logic [WORD_W-1:0] prime_factor;
		logic [WORD_W-1:0] multiplier_k;
		logic [POS_W-1:0]  chain_position;
		logic [WORD_W-1:0] table_word;
	} in_item_t;

	typedef struct packed {
		logic               factor_ok;
		logic [COUNT_W-1:0] cleared_count;
		logic [COUNT_W-1:0] remaining_terms;
	} out_item_t;

endpackage

### sv/chain_factor_verify_and_eliminate.sv
// top level: chain factor verifier with strided candidate bitmap clearing
// Requests enter on in_valid/in_ready (in_data), one result leaves per request on
// out_valid/out_ready (out_data). The user writes configuration via cfg_write,
// cfg_index and cfg_data only while the block is idle; the block does not check.
// After reset the candidate bitmap is set to all ones by a clearing pass over
// all BITMAP_DEPTH entries; in_ready stays low until it ends. Table length, the
// remaining count and the registers return to their reset values at once.
// A verify request runs on a bit-serial modular multiplier and a bit-serial
// remainder unit: base power mode costs up to 64 products, table modes one
// reduction and one product per table word; up to four more reductions and
// two more products follow. A passed check then walks the bitmap one k at a
// time (memory read, then clear).
// One request is worked on at a time. The result sits in an output register;
// a new request is taken while it waits, but the next result is held until
// the receiver takes the previous one.
module chain_factor_verify_and_eliminate #(
	parameter int BITMAP_DEPTH = 65536,
	parameter int TABLE_DEPTH  = 64,
	parameter int MAX_CHAIN    = 30
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  cfve_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output cfve_pkg::out_item_t                  out_data,
	input  logic                                 cfg_write,
	input  logic [cfve_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cfve_pkg::WORD_W-1:0]          cfg_data
);

	localparam int W   = cfve_pkg::WORD_W;
	localparam int AW  = $clog2(BITMAP_DEPTH);
	localparam int RW  = $clog2(BITMAP_DEPTH + 1);
	localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int TLW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [17:0] {
		ST_CLR  = 18'h00001,
		ST_IDLE = 18'h00002,
		ST_BMOD = 18'h00004,
		ST_SQR  = 18'h00008,
		ST_MULB = 18'h00010,
		ST_TRD  = 18'h00020,
		ST_TMOD = 18'h00040,
		ST_TMUL = 18'h00080,
		ST_KMOD = 18'h00100,
		ST_KMUL = 18'h00200,
		ST_MMOD = 18'h00400,
		ST_MMUL = 18'h00800,
		ST_AMOD = 18'h01000,
		ST_CHK  = 18'h02000,
		ST_SMOD = 18'h04000,
		ST_WRD  = 18'h08000,
		ST_WCHK = 18'h10000,
		ST_DONE = 18'h20000
	} state_t;

	state_t state_q;

	// configuration
	logic        chain_kind_q, half_k_q;
	logic [1:0]  term_type_q;
	logic [15:0] base_q;
	logic [31:0] exponent_q;
	logic [W-1:0] min_k_q, max_k_q;

	// request and working values
	logic [W-1:0]  p_q, k_q, one_q, r_q, bm_q, opnd_q;
	logic [4:0]    t_q, bit_q;
	logic [TLW-1:0] tidx_q, table_len_q;
	logic [63:0]   kw_q;
	logic [AW-1:0] widx_q, clr_q;
	logic [RW-1:0] cleared_q, remaining_q;
	logic          ok_q, issued_q;
	logic          out_valid_q;
	cfve_pkg::out_item_t out_q;

	// memories
	logic [W-1:0] table_mem [TABLE_DEPTH];
	logic         bitmap_mem [BITMAP_DEPTH];
	logic [W-1:0] tbl_rd_q;
	logic         bm_rd_q;

	logic          accept, tbl_we, bm_we, bm_wdata, bm_re;
	logic [AW-1:0] bm_waddr;
	logic [W:0]    stride;
	logic [63:0]   mult, offset, idx;

	logic         mul_start, mul_done, mod_start, mod_done, is_mul, is_mod;
	logic [W-1:0] mul_b, mul_res;
	logic [63:0]  mod_x;
	logic [W:0]   mod_m, mod_res;

	function automatic logic [W-1:0] add_m(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] sub_m(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] m);
		logic [W-1:0] d;
		d = a - b;
		if (a < b) begin
			d = d + m;
		end
		return d;
	endfunction

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stride = half_k_q ? {p_q, 1'b0} : {1'b0, p_q};
	assign mult   = 64'd1 << (t_q - 5'd1);
	assign offset = kw_q - {2'b00, min_k_q};
	assign idx    = half_k_q ? (offset >> 1) : offset;

	// shared arithmetic units
	assign is_mul = (state_q == ST_SQR) || (state_q == ST_MULB) || (state_q == ST_TMUL)
		|| (state_q == ST_KMUL) || (state_q == ST_MMUL);
	assign is_mod = (state_q == ST_BMOD) || (state_q == ST_TMOD) || (state_q == ST_KMOD)
		|| (state_q == ST_MMOD) || (state_q == ST_AMOD) || (state_q == ST_SMOD);
	assign mul_start = is_mul && !issued_q;
	assign mod_start = is_mod && !issued_q;

	always_comb begin
		case (state_q)
			ST_SQR:  mul_b = r_q;
			ST_MULB: mul_b = bm_q;
			default: mul_b = opnd_q;
		endcase
		case (state_q)
			ST_BMOD: mod_x = {48'd0, base_q};
			ST_TMOD: mod_x = {2'b00, tbl_rd_q};
			ST_KMOD: mod_x = {2'b00, k_q};
			ST_MMOD: mod_x = mult;
			ST_AMOD: mod_x = mult - 64'd1;
			default: mod_x = {2'b00, min_k_q - k_q};
		endcase
		mod_m = (state_q == ST_SMOD) ? stride : {1'b0, p_q};
	end

	cfve_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (r_q),
		.b      (mul_b),
		.m      (p_q),
		.done   (mul_done),
		.result (mul_res)
	);

	cfve_modred u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.x      (mod_x),
		.m      (mod_m),
		.done   (mod_done),
		.result (mod_res)
	);

	// memory ports
	assign tbl_we = accept && (in_data.command == cfve_pkg::CMD_APPEND)
		&& (in_data.table_word != '0) && (table_len_q < TLW'(TABLE_DEPTH));

	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = widx_q;
		bm_wdata = 1'b0;
		if (state_q == ST_CLR) begin
			bm_we    = 1'b1;
			bm_waddr = clr_q;
			bm_wdata = 1'b1;
		end else if (state_q == ST_WCHK && bm_rd_q) begin
			bm_we = 1'b1;
		end
	end

	assign bm_re = (state_q == ST_WRD);

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			table_mem[table_len_q[TAW-1:0]] <= in_data.table_word;
		end
		if (state_q == ST_TRD) begin
			tbl_rd_q <= table_mem[tidx_q[TAW-1:0]];
		end
		if (bm_we) begin
			bitmap_mem[bm_waddr] <= bm_wdata;
		end
		if (bm_re) begin
			bm_rd_q <= bitmap_mem[idx[AW-1:0]];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_kind_q <= 1'b0;
			term_type_q  <= 2'd0;
			base_q       <= 16'd2;
			exponent_q   <= 32'd3;
			min_k_q      <= W'(1);
			max_k_q      <= W'(1);
			half_k_q     <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				cfve_pkg::REG_CHAIN_KIND: chain_kind_q <= cfg_data[0];
				cfve_pkg::REG_TERM_TYPE:  term_type_q  <= cfg_data[1:0];
				cfve_pkg::REG_BASE:       base_q       <= cfg_data[15:0];
				cfve_pkg::REG_EXPONENT:   exponent_q   <= cfg_data[31:0];
				cfve_pkg::REG_MIN_K:      min_k_q      <= cfg_data;
				cfve_pkg::REG_MAX_K:      max_k_q      <= cfg_data;
				cfve_pkg::REG_HALF_K:     half_k_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			table_len_q <= '0;
			remaining_q <= RW'(BITMAP_DEPTH);
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			cleared_q   <= '0;
			bit_q       <= '0;
			tidx_q      <= '0;
		end else begin
			if (mul_start || mod_start) begin
				issued_q <= 1'b1;
			end else if (mul_done || mod_done) begin
				issued_q <= 1'b0;
			end

			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(BITMAP_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						p_q       <= in_data.prime_factor;
						k_q       <= in_data.multiplier_k;
						t_q       <= in_data.chain_position;
						ok_q      <= 1'b0;
						cleared_q <= '0;
						if (in_data.command == cfve_pkg::CMD_APPEND) begin
							if (tbl_we) begin
								table_len_q <= table_len_q + 1'b1;
								ok_q        <= 1'b1;
							end
							state_q <= ST_DONE;
						end else if (in_data.prime_factor == '0
								|| in_data.chain_position == '0
								|| in_data.chain_position > 5'(MAX_CHAIN)) begin
							state_q <= ST_DONE;
						end else begin
							// one mod p is zero only for p of one
							one_q <= W'(in_data.prime_factor != W'(1));
							r_q   <= W'(in_data.prime_factor != W'(1));
							if (term_type_q == cfve_pkg::TERM_BASE_POWER) begin
								state_q <= ST_BMOD;
							end else begin
								tidx_q  <= '0;
								state_q <= ST_TRD;
							end
						end
					end
				end
				ST_BMOD: begin
					if (mod_done) begin
						bm_q    <= mod_res[W-1:0];
						bit_q   <= 5'd31;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (mul_done) begin
						r_q <= mul_res;
						if (exponent_q[bit_q]) begin
							state_q <= ST_MULB;
						end else if (bit_q == '0) begin
							state_q <= ST_KMOD;
						end else begin
							bit_q   <= bit_q - 1'b1;
							state_q <= ST_SQR;
						end
					end
				end
				ST_MULB: begin
					if (mul_done) begin
						r_q <= mul_res;
						if (bit_q == '0) begin
							state_q <= ST_KMOD;
						end else begin
							bit_q   <= bit_q - 1'b1;
							state_q <= ST_SQR;
						end
					end
				end
				ST_TRD: begin
					if (tidx_q >= table_len_q) begin
						state_q <= ST_KMOD;
					end else begin
						state_q <= ST_TMOD;
					end
				end
				ST_TMOD: begin
					if (mod_done) begin
						opnd_q  <= mod_res[W-1:0];
						state_q <= ST_TMUL;
					end
				end
				ST_TMUL: begin
					if (mul_done) begin
						r_q     <= mul_res;
						tidx_q  <= tidx_q + 1'b1;
						state_q <= ST_TRD;
					end
				end
				ST_KMOD: begin
					if (mod_done) begin
						opnd_q  <= mod_res[W-1:0];
						state_q <= ST_KMUL;
					end
				end
				ST_KMUL: begin
					if (mul_done) begin
						r_q <= chain_kind_q ? add_m(mul_res, one_q, p_q)
							: sub_m(mul_res, one_q, p_q);
						state_q <= (t_q > 5'd1) ? ST_MMOD : ST_CHK;
					end
				end
				ST_MMOD: begin
					if (mod_done) begin
						opnd_q  <= mod_res[W-1:0];
						state_q <= ST_MMUL;
					end
				end
				ST_MMUL: begin
					if (mul_done) begin
						r_q     <= mul_res;
						state_q <= ST_AMOD;
					end
				end
				ST_AMOD: begin
					if (mod_done) begin
						r_q <= chain_kind_q ? sub_m(r_q, mod_res[W-1:0], p_q)
							: add_m(r_q, mod_res[W-1:0], p_q);
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (r_q != '0) begin
						state_q <= ST_DONE;
					end else begin
						ok_q <= 1'b1;
						if (k_q < min_k_q) begin
							state_q <= ST_SMOD;
						end else begin
							kw_q    <= {2'b00, k_q};
							state_q <= ST_WRD;
						end
					end
				end
				ST_SMOD: begin
					// first k of the progression at or above min_k
					if (mod_done) begin
						if (mod_res == '0) begin
							kw_q <= {2'b00, min_k_q};
						end else begin
							kw_q <= {2'b00, min_k_q} + {1'b0, stride} - {1'b0, mod_res};
						end
						state_q <= ST_WRD;
					end
				end
				ST_WRD: begin
					if (kw_q > {2'b00, max_k_q} || idx >= 64'(BITMAP_DEPTH)) begin
						state_q <= ST_DONE;
					end else begin
						widx_q  <= idx[AW-1:0];
						state_q <= ST_WCHK;
					end
				end
				ST_WCHK: begin
					if (bm_rd_q) begin
						cleared_q <= cleared_q + 1'b1;
						if (remaining_q != '0) begin
							remaining_q <= remaining_q - 1'b1;
						end
					end
					kw_q    <= kw_q + {1'b0, stride};
					state_q <= ST_WRD;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_q.factor_ok       <= ok_q;
			out_q.cleared_count   <= cfve_pkg::COUNT_W'(cleared_q);
			out_q.remaining_terms <= cfve_pkg::COUNT_W'(remaining_q);
		end
	end

endmodule

### sv/cfve_mulmod.sv
// bit-serial modular multiplier, one multiplier bit per cycle
module cfve_mulmod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cfve_pkg::WORD_W-1:0] a,
	input  logic [cfve_pkg::WORD_W-1:0] b,
	input  logic [cfve_pkg::WORD_W-1:0] m,
	output logic                        done,
	output logic [cfve_pkg::WORD_W-1:0] result
);

	localparam int W = cfve_pkg::WORD_W;
	localparam int CW = $clog2(W);

	logic [W-1:0]  acc_q, a_q, b_q, m_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W+1:0]  dbl, m1, m2, nx;

	// acc stays below m, so 2*acc + a stays below 3m
	always_comb begin
		dbl = {1'b0, acc_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
		m1  = {2'b00, m_q};
		m2  = {1'b0, m_q, 1'b0};
		if (dbl >= m2) begin
			nx = dbl - m2;
		end else if (dbl >= m1) begin
			nx = dbl - m1;
		end else begin
			nx = dbl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
		end else if (busy_q) begin
			acc_q <= nx[W-1:0];
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

### sv/cfve_modred.sv
// bit-serial remainder unit, one dividend bit per cycle
module cfve_modred (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [63:0]                   x,
	input  logic [cfve_pkg::WORD_W:0]     m,
	output logic                          done,
	output logic [cfve_pkg::WORD_W:0]     result
);

	localparam int MW = cfve_pkg::WORD_W + 1;

	logic [MW-1:0] rem_q, m_q;
	logic [63:0]   x_q;
	logic [5:0]    cnt_q;
	logic          busy_q, done_q;
	logic [MW:0]   sh, nx;

	always_comb begin
		sh = {rem_q, x_q[63]};
		if (sh >= {1'b0, m_q}) begin
			nx = sh - {1'b0, m_q};
		end else begin
			nx = sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			x_q   <= x;
			m_q   <= m;
		end else if (busy_q) begin
			rem_q <= nx[MW-1:0];
			x_q   <= {x_q[62:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = rem_q;

endmodule

### test/tb_chain_factor_verify_and_eliminate.sv
// self-checking testbench for the chain factor verify and eliminate block
module tb_chain_factor_verify_and_eliminate;

	localparam int BMAP = 65536;
	localparam int TDEPTH = 64;
	localparam int CHAIN_MAX = 30;
	localparam int WW = cfve_pkg::WORD_W;
	localparam int CW = cfve_pkg::COUNT_W;
	localparam int PW = cfve_pkg::POS_W;
	localparam logic [WW-1:0] WMAX = {WW{1'b1}};
	localparam logic [1:0] TERM_PRIMORIAL = 2'd1;
	localparam logic [1:0] TERM_FACTORIAL = 2'd2;
	localparam logic [1:0] TERM_SPARE = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		cfve_pkg::in_item_t  req;
		bit                  typed;
		cfve_pkg::out_item_t want;
	} dir_row_t;

	typedef struct {
		bit          kind;
		logic [1:0]  ttype;
		logic [15:0] b;
		logic [31:0] n;
		logic [WW-1:0] lo_k;
		logic [WW-1:0] hi_k;
		bit          halve;
		int          pbits;
		int          nitems;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	cfve_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	cfve_pkg::out_item_t out_data;
	logic cfg_write = 1'b0;
	logic [cfve_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [WW-1:0] cfg_data = '0;

	chain_factor_verify_and_eliminate uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// mirror of the block state
	bit                candidates [BMAP];
	logic [WW-1:0]     words [TDEPTH];
	int                word_count;
	int                live_terms;
	bit                m_kind;
	logic [1:0]        m_ttype;
	logic [15:0]       m_base;
	logic [31:0]       m_exp;
	logic [WW-1:0]     m_min_k;
	logic [WW-1:0]     m_max_k;
	bit                m_half;

	cfve_pkg::out_item_t pending_outcomes [$];
	int                  errors = 0;
	idle_mode_t          idle_mode = IDLE_NONE;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#500_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		logic [127:0] x;
		x = {64'b0, a} * {64'b0, b};
		return 64'(x % {64'b0, m});
	endfunction

	function automatic logic [63:0] powmod(logic [63:0] b, logic [31:0] e, logic [63:0] m);
		logic [63:0] r;
		r = 64'd1 % m;
		for (int i = 31; i >= 0; i--) begin
			r = mulmod(r, r, m);
			if (e[i])
				r = mulmod(r, b, m);
		end
		return r;
	endfunction

	// M modulo p
	function automatic logic [63:0] term_residue(logic [63:0] p);
		logic [63:0] r;
		if (m_ttype == cfve_pkg::TERM_BASE_POWER)
			return powmod({48'b0, m_base} % p, m_exp, p);
		r = 64'd1 % p;
		for (int i = 0; i < word_count; i++)
			r = mulmod(r, {2'b0, words[i]} % p, p);
		return r;
	endfunction

	function automatic bit factor_holds(logic [63:0] p, logic [63:0] k, int t);
		logic [63:0] r, one, mult, addend;
		one = 64'd1 % p;
		r = mulmod(term_residue(p), k % p, p);
		r = m_kind ? (r + one) % p : (r + p - one) % p;
		if (t > 1) begin
			mult = 64'd1 << (t - 1);
			addend = (mult - 1) % p;
			r = mulmod(r, mult % p, p);
			r = m_kind ? (r + p - addend) % p : (r + addend) % p;
		end
		return r == 0;
	endfunction

	function automatic int clear_progression(logic [63:0] p, logic [63:0] k);
		logic [63:0] stride, steps, idx;
		int n;
		n = 0;
		stride = m_half ? (p << 1) : p;
		if (k < {2'b0, m_min_k}) begin
			steps = ({2'b0, m_min_k} - k + stride - 1) / stride;
			k += steps * stride;
		end
		while (k <= {2'b0, m_max_k}) begin
			idx = m_half ? ((k - {2'b0, m_min_k}) >> 1) : (k - {2'b0, m_min_k});
			if (idx >= BMAP)
				break;
			if (candidates[idx]) begin
				candidates[idx] = 0;
				n++;
				if (live_terms > 0)
					live_terms--;
			end
			k += stride;
		end
		return n;
	endfunction

	function automatic cfve_pkg::out_item_t predict_outcome(cfve_pkg::in_item_t rq);
		cfve_pkg::out_item_t o;
		o = '0;
		if (rq.command == cfve_pkg::CMD_APPEND) begin
			if (rq.table_word != 0 && word_count < TDEPTH) begin
				words[word_count] = rq.table_word;
				word_count++;
				o.factor_ok = 1'b1;
			end
		end else if (rq.prime_factor != 0 && rq.chain_position >= 1 &&
				rq.chain_position <= CHAIN_MAX) begin
			if (factor_holds({2'b0, rq.prime_factor}, {2'b0, rq.multiplier_k},
					int'(rq.chain_position))) begin
				o.factor_ok = 1'b1;
				o.cleared_count = CW'(clear_progression({2'b0, rq.prime_factor},
					{2'b0, rq.multiplier_k}));
			end
		end
		o.remaining_terms = CW'(live_terms);
		return o;
	endfunction

	function automatic logic [63:0] inverse_mod(logic [63:0] a, logic [63:0] m);
		longint r0, r1, s0, s1, q, tmp;
		r0 = longint'(m);
		r1 = longint'(a % m);
		s0 = 0;
		s1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1; r0 = r1; r1 = tmp;
			tmp = s0 - q * s1; s0 = s1; s1 = tmp;
		end
		if (r0 != 1)
			return 0;
		if (s0 < 0)
			s0 += longint'(m);
		return 64'(s0);
	endfunction

	function automatic logic [WW-1:0] rand_word();
		return WW'({$urandom, $urandom});
	endfunction

	function automatic bit sender_rests();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(0, 99) < 54;
			IDLE_BOTH:   return $urandom_range(0, 99) < 6;
			default:     return 0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(0, 99) < 54;
			IDLE_BOTH:     return $urandom_range(0, 99) < 6;
			default:       return 0;
		endcase
	endfunction

	function automatic cfve_pkg::in_item_t mk_req(logic cmd, logic [WW-1:0] p,
			logic [WW-1:0] k, logic [PW-1:0] t, logic [WW-1:0] w);
		cfve_pkg::in_item_t r;
		r.command = cmd;
		r.prime_factor = p;
		r.multiplier_k = k;
		r.chain_position = t;
		r.table_word = w;
		return r;
	endfunction

	function automatic dir_row_t row(cfve_pkg::in_item_t rq, bit typed, logic ok, int clr,
			int rem);
		dir_row_t d;
		d.req = rq;
		d.typed = typed;
		d.want.factor_ok = ok;
		d.want.cleared_count = CW'(clr);
		d.want.remaining_terms = CW'(rem);
		return d;
	endfunction

	function automatic phase_t ph(bit kind, logic [1:0] tt, logic [15:0] b, logic [31:0] n,
			logic [WW-1:0] lo, logic [WW-1:0] hi, bit halve, int pbits, int cnt);
		phase_t x;
		x.kind = kind; x.ttype = tt; x.b = b; x.n = n;
		x.lo_k = lo; x.hi_k = hi; x.halve = halve;
		x.pbits = pbits; x.nitems = cnt;
		return x;
	endfunction

	// caller stands just after a falling edge
	task automatic send_request(cfve_pkg::in_item_t rq);
		while (sender_rests()) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = rq;
		do @(posedge clk); while (!in_ready);
		pending_outcomes.push_back(predict_outcome(rq));
		@(negedge clk);
	endtask

	task automatic send_typed(cfve_pkg::in_item_t rq, cfve_pkg::out_item_t want);
		cfve_pkg::out_item_t ignored;
		in_valid = 1'b1;
		in_data = rq;
		do @(posedge clk); while (!in_ready);
		ignored = predict_outcome(rq);
		pending_outcomes.push_back(want);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [cfve_pkg::CFG_IDX_W-1:0] idx, logic [WW-1:0] val);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		case (idx)
			cfve_pkg::REG_CHAIN_KIND: m_kind = val[0];
			cfve_pkg::REG_TERM_TYPE:  m_ttype = val[1:0];
			cfve_pkg::REG_BASE:       m_base = val[15:0];
			cfve_pkg::REG_EXPONENT:   m_exp = val[31:0];
			cfve_pkg::REG_MIN_K:      m_min_k = val;
			cfve_pkg::REG_MAX_K:      m_max_k = val;
			cfve_pkg::REG_HALF_K:     m_half = val[0];
			default: ;
		endcase
	endtask

	task automatic load_phase(phase_t x);
		write_reg(cfve_pkg::REG_CHAIN_KIND, WW'(x.kind));
		write_reg(cfve_pkg::REG_TERM_TYPE, WW'(x.ttype));
		write_reg(cfve_pkg::REG_BASE, WW'(x.b));
		write_reg(cfve_pkg::REG_EXPONENT, WW'(x.n));
		write_reg(cfve_pkg::REG_MIN_K, x.lo_k);
		write_reg(cfve_pkg::REG_MAX_K, x.hi_k);
		write_reg(cfve_pkg::REG_HALF_K, WW'(x.halve));
		cfg_write = 1'b0;
	endtask

	// a verify request whose k satisfies the check when the residue is invertible, placed near the bitmap window
	function automatic cfve_pkg::in_item_t solvable_request(int pbits);
		logic [63:0] p, x, inv, k0, span, m;
		longint tgt, d, k;
		int t;
		p = {2'b0, rand_word()} & ((64'd1 << pbits) - 1);
		p = p | (64'd1 << (pbits - 1)) | 64'd1;
		if (p < 3)
			p = 3;
		t = $urandom_range(1, CHAIN_MAX);
		x = mulmod((64'd1 << (t - 1)) % p, term_residue(p), p);
		inv = inverse_mod(x, p);
		if (inv == 0)
			return mk_req(cfve_pkg::CMD_VERIFY, WW'(p), rand_word(), PW'(t), rand_word());
		k0 = m_kind ? (p - inv) % p : inv;
		if (k0 == 0)
			k0 = p;
		span = {2'b0, m_max_k} - {2'b0, m_min_k};
		if (m_max_k < m_min_k || span > 64'd1 << 20)
			span = 64'd1 << 20;
		m = {$urandom, $urandom} % (span + 1);
		tgt = longint'(m_min_k) + longint'(m);
		if ($urandom_range(0, 99) < 20)
			tgt = longint'(m_min_k) - longint'({$urandom, $urandom} % (2 * p));
		d = (tgt - longint'(k0)) % longint'(p);
		if (d < 0)
			d += longint'(p);
		k = tgt - d;
		if (k < 1)
			k += longint'(p);
		if (k > longint'({2'b0, WMAX}) || k < 1)
			k = longint'(k0);
		return mk_req(cfve_pkg::CMD_VERIFY, WW'(p), WW'(k), PW'(t), rand_word());
	endfunction

	function automatic cfve_pkg::in_item_t random_request(int pbits);
		int roll;
		logic [WW-1:0] w;
		roll = $urandom_range(0, 99);
		if (roll < 25) begin
			w = ($urandom_range(0, 9) == 0) ? '0 : rand_word();
			return mk_req(cfve_pkg::CMD_APPEND, rand_word(), rand_word(), PW'($urandom), w);
		end
		if (roll < 35)
			return mk_req(cfve_pkg::CMD_VERIFY,
				($urandom_range(0, 19) == 0) ? '0 : rand_word(),
				rand_word(), PW'($urandom), rand_word());
		return solvable_request(pbits);
	endfunction

	always @(negedge clk)
		out_ready <= arst_n && !receiver_stalls();

	always @(posedge clk) begin
		cfve_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no request outstanding: %h", out_data);
				errors++;
			end else begin
				want = pending_outcomes.pop_front();
				if (out_data.factor_ok !== want.factor_ok) begin
					$error("factor_ok expected %0d got %0d", want.factor_ok,
						out_data.factor_ok);
					errors++;
				end
				if (out_data.cleared_count !== want.cleared_count) begin
					$error("cleared_count expected %0d got %0d", want.cleared_count,
						out_data.cleared_count);
					errors++;
				end
				if (out_data.remaining_terms !== want.remaining_terms) begin
					$error("remaining_terms expected %0d got %0d", want.remaining_terms,
						out_data.remaining_terms);
					errors++;
				end
			end
		end
	end

	initial begin
		dir_row_t rows [$];
		phase_t phases [$];
		for (int i = 0; i < BMAP; i++)
			candidates[i] = 1;
		word_count = 0;
		live_terms = BMAP;
		m_kind = 0; m_ttype = cfve_pkg::TERM_BASE_POWER; m_base = 2; m_exp = 3;
		m_min_k = 1; m_max_k = 1; m_half = 0;

		rows = '{
			row(mk_req(cfve_pkg::CMD_VERIFY, '0, 1, 1, 5), 1, 0, 0, BMAP),
			row(mk_req(cfve_pkg::CMD_VERIFY, 7, 1, 0, 5), 1, 0, 0, BMAP),
			row(mk_req(cfve_pkg::CMD_VERIFY, 7, 1, 31, 5), 1, 0, 0, BMAP),
			row(mk_req(cfve_pkg::CMD_APPEND, WMAX, WMAX, 3, '0), 1, 0, 0, BMAP),
			row(mk_req(cfve_pkg::CMD_VERIFY, 3, 1, 1, 0), 1, 0, 0, BMAP),
			row(mk_req(cfve_pkg::CMD_VERIFY, 7, 1, 1, 0), 1, 1, 1, BMAP - 1),
			row(mk_req(cfve_pkg::CMD_VERIFY, 7, 1, 1, 0), 1, 1, 0, BMAP - 1),
			row(mk_req(cfve_pkg::CMD_VERIFY, WMAX, WMAX, CHAIN_MAX, WMAX), 0, 0, 0, 0),
			row(mk_req(cfve_pkg::CMD_VERIFY, 3, WMAX, CHAIN_MAX, 0), 0, 0, 0, 0),
			row(mk_req(cfve_pkg::CMD_VERIFY, WMAX, 1, 1, 0), 0, 0, 0, 0),
			row(mk_req(cfve_pkg::CMD_VERIFY, 5, 1, 2, 0), 0, 0, 0, 0),
			row(mk_req(cfve_pkg::CMD_VERIFY, 7, 1, CHAIN_MAX, 0), 0, 0, 0, 0),
			row(mk_req(cfve_pkg::CMD_APPEND, 0, 0, 0, WMAX), 1, 1, 0, BMAP - 1),
			row(mk_req(cfve_pkg::CMD_APPEND, WMAX, 0, 31, 1), 1, 1, 0, BMAP - 1),
			row(mk_req(cfve_pkg::CMD_APPEND, 3, 3, 3, 2), 1, 1, 0, BMAP - 1)
		};
		phases = '{
			ph(0, cfve_pkg::TERM_BASE_POWER, 2, 3, 1, 1000, 0, 12, 180),
			ph(1, cfve_pkg::TERM_BASE_POWER, 32768, 32'h8000_0000, 100, 3000, 1, 16, 160),
			ph(0, TERM_PRIMORIAL, 3, 5, 1, WMAX, 0, 14, 140),
			ph(1, TERM_FACTORIAL, 7, 9, WMAX, WMAX, 0, 62, 140),
			ph(0, TERM_SPARE, 0, 0, 5000, 9000, 1, 10, 160),
			ph(1, cfve_pkg::TERM_BASE_POWER, 16'hFFFF, 32'hFFFF_FFFF, 1, 70000, 0, 8, 180),
			ph(0, TERM_PRIMORIAL, 5, 4, 200, 4000, 1, 20, 200),
			ph(1, cfve_pkg::TERM_BASE_POWER, 2, 3, 1, 2000, 0, 6, 140)
		};

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			if (rows[i].typed)
				send_typed(rows[i].req, rows[i].want);
			else
				send_request(rows[i].req);
		end
		drain();

		foreach (phases[i]) begin
			load_phase(phases[i]);
			idle_mode = idle_mode_t'(i % 4);
			for (int j = 0; j < phases[i].nitems; j++) begin
				// hold back until the block has answered everything so far
				if (j == phases[i].nitems / 2) begin
					in_valid = 1'b0;
					while (pending_outcomes.size() != 0)
						@(negedge clk);
				end
				send_request(random_request(phases[i].pbits));
			end
			drain();
		end

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
